// ===== hdl/plt_pkg.sv =====
// ----------------------------------------------------------------------------
// plt_pkg
// Types and constants shared by the piecewise linear table lookup block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package plt_pkg;

	localparam int DATA_W  = 32;
	localparam int INDEX_W = 6;
	localparam int CFG_W   = 7;
	localparam int STAT_W  = 2;
	localparam int DIFF_W  = DATA_W + 1;
	localparam int PROD_W  = 2 * DATA_W;
	localparam int QUOT_W  = 35;
	localparam int SUM_W   = 36;

	// quotient is clamped to 2^34, far outside the 32-bit result range
	localparam logic [QUOT_W-1:0] QUOT_MAX = {1'b1, {(QUOT_W-1){1'b0}}};

	localparam logic signed [SUM_W-1:0] SAT_HI = 36'sh0_7FFF_FFFF;
	localparam logic signed [SUM_W-1:0] SAT_LO = 36'shF_8000_0000;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_INTERP = 2'd0,
		ST_BELOW  = 2'd1,
		ST_ABOVE  = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIRST,
		S_LAST,
		S_SCAN,
		S_SEG_LO,
		S_SEG_HI,
		S_DIFF,
		S_MUL,
		S_DSTART,
		S_DIV,
		S_SUM,
		S_DONE
	} state_t;

endpackage

// ===== hdl/plt_if.sv =====
// ----------------------------------------------------------------------------
// plt_if
// Valid/ready channels of the table lookup: request, response, configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface plt_req_if import plt_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     cmd;
	logic [INDEX_W-1:0]       entry_index;
	logic signed [DATA_W-1:0] key;
	logic signed [DATA_W-1:0] entry_value;

	modport source (output valid, cmd, entry_index, key, entry_value, input ready);
	modport sink (input valid, cmd, entry_index, key, entry_value, output ready);
endinterface

interface plt_rsp_if import plt_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] result;
	logic [STAT_W-1:0]        status;

	modport source (output valid, result, status, input ready);
	modport sink (input valid, result, status, output ready);
endinterface

interface plt_cfg_if import plt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== hdl/piecewise_linear_table_lookup.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_table_lookup
// One-dimensional linear interpolation over a table of signed Q16.16
// breakpoints. A write word (cmd 0) stores key/value at entry_index;
// entries at or above ENTRIES are dropped. A query word (cmd 1) returns
// one response: the interpolated value (status 0), the first value when
// key is below the first breakpoint (1), the last value when above the
// last breakpoint (2), or zero on an empty table (3). Keys must be
// written before they are queried and must be strictly increasing over the
// active_entries in use. The block takes one word at a time: a query
// occupies it until its response is registered, an interpolated one for
// the linear segment scan through the single table read port and the
// bit-serial divide. A finished response may wait on the output register
// while the next word is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module piecewise_linear_table_lookup import plt_pkg::*; #(
	parameter int ENTRIES = 64
) (
	input  logic clk,
	input  logic arst_n,
	plt_req_if.sink   req,
	plt_rsp_if.source rsp,
	plt_cfg_if.sink   cfg
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int NW = $clog2(ENTRIES + 1);

	state_t state_q, state_d;

	logic [CFG_W-1:0]         active_q;
	logic [NW-1:0]            n_q;
	logic [NW-1:0]            n_new;
	logic [AW-1:0]            cnt_q;
	logic [AW-1:0]            seg_q;
	logic                     prev_ge_q;
	logic signed [DATA_W-1:0] x_q;
	logic signed [DATA_W-1:0] k1_q;
	logic signed [DATA_W-1:0] v1_q;
	logic [DATA_W-1:0]        ma_q, mb_q, md_q;
	logic                     neg_q;
	logic                     zero_q;
	logic [PROD_W-1:0]        prod_q;
	logic [QUOT_W-1:0]        q_q;
	logic signed [DATA_W-1:0] res_q;
	status_t                  st_q;
	logic                     rsp_valid_q;
	logic signed [DATA_W-1:0] rsp_result_q;
	logic [STAT_W-1:0]        rsp_status_q;

	logic                     req_fire;
	logic                     wr_en;
	logic [AW-1:0]            rd_addr;
	logic signed [DATA_W-1:0] rd_key;
	logic signed [DATA_W-1:0] rd_val;
	logic                     last_idx;
	logic                     hit;
	logic                     out_free;

	logic signed [DIFF_W-1:0] a_diff, b_diff, d_diff;
	logic [DIFF_W-1:0]        a_mag, b_mag, d_mag;
	logic signed [SUM_W-1:0]  v1_ext, q_ext, sum;

	logic                     div_start;
	logic                     div_done;
	logic [QUOT_W-1:0]        div_quot;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign req_fire  = req.valid && req.ready;
	assign wr_en     = req_fire && (req.cmd == CMD_WRITE)
		&& ({{(DATA_W-INDEX_W){1'b0}}, req.entry_index} < DATA_W'(ENTRIES));
	assign n_new     = ({{(DATA_W-CFG_W){1'b0}}, active_q} > DATA_W'(ENTRIES))
		? NW'(ENTRIES) : NW'(active_q);

	assign last_idx  = (NW'(cnt_q) == n_q - NW'(1));
	assign hit       = prev_ge_q && (x_q < rd_key);
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign div_start = (state_q == S_DSTART);

	plt_table #(.ENTRIES(ENTRIES), .AW(AW)) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(AW'(req.entry_index)),
		.wr_key (req.key),
		.wr_val (req.entry_value),
		.rd_addr(rd_addr),
		.rd_key (rd_key),
		.rd_val (rd_val)
	);

	plt_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(prod_q),
		.divisor (md_q),
		.done    (div_done),
		.quot    (div_quot)
	);

	// segment differences, taken when the upper breakpoint arrives
	assign a_diff = DIFF_W'(x_q) - DIFF_W'(k1_q);
	assign b_diff = DIFF_W'(rd_val) - DIFF_W'(v1_q);
	assign d_diff = DIFF_W'(rd_key) - DIFF_W'(k1_q);
	assign a_mag  = a_diff[DIFF_W-1] ? -a_diff : a_diff;
	assign b_mag  = b_diff[DIFF_W-1] ? -b_diff : b_diff;
	assign d_mag  = d_diff[DIFF_W-1] ? -d_diff : d_diff;

	assign v1_ext = SUM_W'(v1_q);
	assign q_ext  = signed'({1'b0, q_q});
	assign sum    = neg_q ? (v1_ext - q_ext) : (v1_ext + q_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_addr = '0;
		case (state_q)
			S_IDLE: begin
				if (req_fire && req.cmd == CMD_QUERY) begin
					state_d = (n_new == '0) ? S_DONE : S_FIRST;
				end
			end
			S_FIRST: begin
				rd_addr = AW'(n_q - NW'(1));
				state_d = (x_q < rd_key) ? S_DONE : S_LAST;
			end
			S_LAST: begin
				rd_addr = AW'(1);
				if (x_q > rd_key || n_q == NW'(1)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				rd_addr = cnt_q + AW'(1);
				if (hit || last_idx) begin
					state_d = S_SEG_LO;
				end
			end
			S_SEG_LO: begin
				rd_addr = seg_q;
				state_d = S_SEG_HI;
			end
			S_SEG_HI: begin
				rd_addr = seg_q + AW'(1);
				state_d = S_DIFF;
			end
			S_DIFF: begin
				state_d = S_MUL;
			end
			S_MUL: begin
				state_d = zero_q ? S_SUM : S_DSTART;
			end
			S_DSTART: begin
				state_d = S_DIV;
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_SUM;
				end
			end
			S_SUM: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				x_q   <= req.key;
				n_q   <= n_new;
				res_q <= '0;
				st_q  <= ST_EMPTY;
			end
			S_FIRST: begin
				res_q <= rd_val;
				st_q  <= ST_BELOW;
			end
			S_LAST: begin
				res_q     <= rd_val;
				st_q      <= (x_q > rd_key) ? ST_ABOVE : ST_INTERP;
				cnt_q     <= AW'(1);
				prev_ge_q <= 1'b1;
			end
			S_SCAN: begin
				// first segment with key[i-1] <= x < key[i]; fall back to the last one
				if (hit) begin
					seg_q <= cnt_q - AW'(1);
				end else if (last_idx) begin
					seg_q <= AW'(n_q - NW'(2));
				end
				prev_ge_q <= (x_q >= rd_key);
				cnt_q     <= cnt_q + AW'(1);
			end
			S_SEG_HI: begin
				k1_q <= rd_key;
				v1_q <= rd_val;
			end
			S_DIFF: begin
				ma_q   <= a_mag[DATA_W-1:0];
				mb_q   <= b_mag[DATA_W-1:0];
				md_q   <= d_mag[DATA_W-1:0];
				neg_q  <= a_diff[DIFF_W-1] ^ b_diff[DIFF_W-1] ^ d_diff[DIFF_W-1];
				zero_q <= (a_diff == '0) || (b_diff == '0) || (d_diff == '0);
			end
			S_MUL: begin
				prod_q <= ma_q * mb_q;
				q_q    <= '0;
			end
			S_DIV: begin
				if (div_done) begin
					q_q <= div_quot;
				end
			end
			S_SUM: begin
				st_q <= ST_INTERP;
				if (sum > SAT_HI) begin
					res_q <= SAT_HI[DATA_W-1:0];
				end else if (sum < SAT_LO) begin
					res_q <= SAT_LO[DATA_W-1:0];
				end else begin
					res_q <= sum[DATA_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				active_q <= cfg.data;
			end
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			rsp_result_q <= res_q;
			rsp_status_q <= st_q;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.result = rsp_result_q;
	assign rsp.status = rsp_status_q;

endmodule

// ===== hdl/plt_table.sv =====
// ----------------------------------------------------------------------------
// plt_table
// Breakpoint key and value memories, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plt_table import plt_pkg::*; #(
	parameter int ENTRIES = 64,
	parameter int AW      = 6
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [AW-1:0]            wr_addr,
	input  logic signed [DATA_W-1:0] wr_key,
	input  logic signed [DATA_W-1:0] wr_val,
	input  logic [AW-1:0]            rd_addr,
	output logic signed [DATA_W-1:0] rd_key,
	output logic signed [DATA_W-1:0] rd_val
);

	logic signed [DATA_W-1:0] key_mem [ENTRIES];
	logic signed [DATA_W-1:0] val_mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			val_mem[wr_addr] <= wr_val;
		end
	end

	always_ff @(posedge clk) begin
		rd_key <= key_mem[rd_addr];
		rd_val <= val_mem[rd_addr];
	end

endmodule

// ===== hdl/plt_div.sv =====
// ----------------------------------------------------------------------------
// plt_div
// Restoring divider, one quotient bit per cycle, 64-bit by 32-bit unsigned.
// Quotient is clamped to 2^34.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plt_div import plt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [QUOT_W-1:0] quot
);

	localparam int CW = $clog2(PROD_W);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [PROD_W-1:0] dq_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   trial;
	logic              fits;
	logic              over;

	assign shifted = {rem_q, dq_q[PROD_W-1]};
	assign trial   = shifted - {1'b0, divisor};
	assign fits    = (shifted >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CW'(PROD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// dividend shifts out the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			cnt_q <= '0;
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			dq_q  <= {dq_q[PROD_W-2:0], fits};
			rem_q <= fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
		end
	end

	assign over = (|dq_q[PROD_W-1:QUOT_W]) || (dq_q[QUOT_W-1] && (|dq_q[QUOT_W-2:0]));
	assign quot = over ? QUOT_MAX : dq_q[QUOT_W-1:0];
	assign done = done_q;

endmodule
